@@ hdl/srx_pkg.sv @@
`default_nettype none
package srx_pkg;

    localparam int unsigned PAYLOAD_DEPTH_DEF = 256;
    localparam int unsigned QUEUE_DEPTH       = 2;
    localparam int unsigned CFG_INDEX_W       = 2;

    localparam logic [7:0]  SYNC_FIRST_RST  = 8'hAA;
    localparam logic [7:0]  SYNC_SECOND_RST = 8'h55;
    localparam logic [15:0] CRC_INIT        = 16'hFFFF;
    localparam logic [15:0] CRC_POLY        = 16'h1021;
    localparam logic [7:0]  MIN_LENGTH      = 8'd5;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_SYNC_FIRST  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_SYNC_SECOND = CFG_INDEX_W'(1);

    // item kinds, shared by input and result
    localparam logic KIND_LINE = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef enum logic [3:0] {
        ST_HUNT    = 4'd0,
        ST_SYNC2   = 4'd1,
        ST_LEN     = 4'd2,
        ST_TYPE    = 4'd3,
        ST_SEQH    = 4'd4,
        ST_SEQL    = 4'd5,
        ST_PAYLOAD = 4'd6,
        ST_CRCH    = 4'd7,
        ST_CRCL    = 4'd8
    } t_fstate;

    // one classified item as it travels from front to back
    typedef struct packed {
        logic       kind;
        logic [7:0] rx_byte;
        logic [7:0] read_index;
        logic       hit_first;
        logic       hit_second;
    } t_item;

    // one result held in the output register
    typedef struct packed {
        logic        kind;
        logic [7:0]  pkt_type;
        logic [15:0] pkt_seq;
        logic [7:0]  pkt_len;
    } t_result;

    // CRC-16, MSB first, one byte
    function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

@@ hdl/sync_length_crc16_frame_receiver.sv @@
`default_nettype none
// Sync/length framed receiver with CRC-16/CCITT-FALSE check. Each input beat
// is either a line byte (kind 0) or a read of one stored payload byte (kind 1).
// A frame is sync_first, sync_second, length L (>= 5), type, sequence (2 bytes,
// big-endian), L-5 payload bytes and a big-endian CRC over everything from the
// first sync byte through the payload. A good frame yields one result beat with
// type, sequence and payload length; a bad CRC, short length or wrong second
// sync is dropped without a result. Every read beat yields one result beat;
// only store entries written by the current or last frame are meaningful, and
// an index at or above PAYLOAD_DEPTH reads 0. The block takes one beat per
// clock cycle: the front tags sync matches and pushes into a two-entry queue,
// the back steps the frame state, updates the CRC one byte per cycle and owns
// the payload store and the output register. A result is presented from the
// output register: the accepted beat is first written into the queue, and the
// back loads the output register at the same edge as it pops that beat. While a
// result waits on the output, the back holds every beat, and the input side
// stalls once the queue is full. Write the sync registers only while no beat
// is in flight; the configuration port is always ready.
module sync_length_crc16_frame_receiver #(
    parameter int unsigned PAYLOAD_DEPTH = srx_pkg::PAYLOAD_DEPTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic                            i_kind,
    input  wire logic [7:0]                      i_rx_byte,
    input  wire logic [7:0]                      i_read_index,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [srx_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [7:0]                      i_cfg_data,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic                                 o_result_kind,
    output logic [7:0]                           o_pkt_type,
    output logic [15:0]                          o_pkt_seq,
    output logic [7:0]                           o_pkt_len,
    output logic [7:0]                           o_read_data
);
    import srx_pkg::*;

    logic  push, q_not_full, q_not_empty, pop;
    t_item front_item, head_item;

    // front: config registers and sync classification
    srx_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_kind       (i_kind),
        .i_rx_byte    (i_rx_byte),
        .i_read_index (i_read_index),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_push       (push),
        .o_item       (front_item),
        .i_q_not_full (q_not_full)
    );

    // decouple front from back so either side can stall
    srx_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (front_item),
        .o_not_full  (q_not_full),
        .o_not_empty (q_not_empty),
        .i_pop       (pop),
        .o_item      (head_item)
    );

    logic back_ready;
    assign pop = q_not_empty && back_ready;

    // back: frame walk, CRC, payload store, output register
    srx_back #(
        .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item_valid  (q_not_empty),
        .o_item_ready  (back_ready),
        .i_item        (head_item),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_result_kind (o_result_kind),
        .o_pkt_type    (o_pkt_type),
        .o_pkt_seq     (o_pkt_seq),
        .o_pkt_len     (o_pkt_len),
        .o_read_data   (o_read_data)
    );

endmodule
`default_nettype wire

@@ hdl/srx_front.sv @@
`default_nettype none
module srx_front (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic                            i_kind,
    input  wire logic [7:0]                      i_rx_byte,
    input  wire logic [7:0]                      i_read_index,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [srx_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [7:0]                      i_cfg_data,
    output logic                                 o_push,
    output srx_pkg::t_item                       o_item,
    input  wire logic                            i_q_not_full
);
    import srx_pkg::*;

    logic [7:0] r_sync_first;
    logic [7:0] r_sync_second;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_first  <= SYNC_FIRST_RST;
            r_sync_second <= SYNC_SECOND_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_SYNC_FIRST:  r_sync_first  <= i_cfg_data;
                REG_SYNC_SECOND: r_sync_second <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_in_ready = i_q_not_full;
    assign o_push     = i_in_valid && i_q_not_full;

    // tag sync matches up front so the back only steers
    always_comb begin
        o_item.kind       = i_kind;
        o_item.rx_byte    = i_rx_byte;
        o_item.read_index = i_read_index;
        o_item.hit_first  = (i_rx_byte == r_sync_first);
        o_item.hit_second = (i_rx_byte == r_sync_second);
    end

endmodule
`default_nettype wire

@@ hdl/srx_queue.sv @@
`default_nettype none
module srx_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire srx_pkg::t_item i_item,
    output logic                o_not_full,
    output logic                o_not_empty,
    input  wire logic           i_pop,
    output srx_pkg::t_item      o_item
);
    import srx_pkg::*;

    localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

    t_item          r_slot [QUEUE_DEPTH];
    logic [PW-1:0]  r_wr_ptr;
    logic [PW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;

    assign o_not_full  = (r_count != CW'(QUEUE_DEPTH));
    assign o_not_empty = (r_count != '0);
    assign o_item      = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule
`default_nettype wire

@@ hdl/srx_back.sv @@
`default_nettype none
module srx_back #(
    parameter int unsigned PAYLOAD_DEPTH = srx_pkg::PAYLOAD_DEPTH_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_item_valid,
    output logic                o_item_ready,
    input  wire srx_pkg::t_item i_item,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output logic                o_result_kind,
    output logic [7:0]          o_pkt_type,
    output logic [15:0]         o_pkt_seq,
    output logic [7:0]          o_pkt_len,
    output logic [7:0]          o_read_data
);
    import srx_pkg::*;

    localparam int unsigned AW = $clog2(PAYLOAD_DEPTH);

    t_fstate     r_state, n_state;
    logic [7:0]  r_len;
    logic [7:0]  r_type;
    logic [15:0] r_seq;
    logic [7:0]  r_wpos;
    logic [15:0] r_crc;
    logic [7:0]  r_crc_high;
    logic [7:0]  r_store [PAYLOAD_DEPTH];
    logic [7:0]  r_rd_data;
    logic        r_rd_oor;
    logic        r_out_valid;
    t_result     r_out;

    logic        pop, line, rd;
    logic        payload_last;
    logic [15:0] crc_next;

    // control decoded from the current state and byte
    logic crc_en, crc_from_init, len_ld, type_ld, seqh_ld, seql_ld, crch_ld;
    logic store_we, wpos_clr, frame_hit;

    assign o_item_ready = !r_out_valid || i_out_ready;
    assign pop  = i_item_valid && o_item_ready;
    assign line = pop && (i_item.kind == KIND_LINE);
    assign rd   = pop && (i_item.kind == KIND_READ);

    assign payload_last = ({1'b0, r_wpos} + 9'd1) >= {1'b0, r_len - MIN_LENGTH};
    assign crc_next     = crc_add(crc_from_init ? CRC_INIT : r_crc, i_item.rx_byte);

    always_comb begin
        n_state = r_state;
        if (line) begin
            unique case (r_state)
                ST_SYNC2:   n_state = i_item.hit_second ? ST_LEN : ST_HUNT;
                ST_LEN:     n_state = (i_item.rx_byte < MIN_LENGTH) ? ST_HUNT : ST_TYPE;
                ST_TYPE:    n_state = ST_SEQH;
                ST_SEQH:    n_state = ST_SEQL;
                ST_SEQL:    n_state = (r_len == MIN_LENGTH) ? ST_CRCH : ST_PAYLOAD;
                ST_PAYLOAD: n_state = payload_last ? ST_CRCH : ST_PAYLOAD;
                ST_CRCH:    n_state = ST_CRCL;
                ST_CRCL:    n_state = ST_HUNT;
                default:    n_state = i_item.hit_first ? ST_SYNC2 : ST_HUNT;
            endcase
        end
    end

    always_comb begin
        crc_en        = 1'b0;
        crc_from_init = 1'b0;
        len_ld        = 1'b0;
        type_ld       = 1'b0;
        seqh_ld       = 1'b0;
        seql_ld       = 1'b0;
        crch_ld       = 1'b0;
        store_we      = 1'b0;
        wpos_clr      = 1'b0;
        frame_hit     = 1'b0;
        if (line) begin
            unique case (r_state)
                ST_SYNC2:   crc_en = i_item.hit_second;
                ST_LEN: begin
                    len_ld   = 1'b1;
                    crc_en   = (i_item.rx_byte >= MIN_LENGTH);
                    wpos_clr = (i_item.rx_byte >= MIN_LENGTH);
                end
                ST_TYPE: begin
                    type_ld = 1'b1;
                    crc_en  = 1'b1;
                end
                ST_SEQH: begin
                    seqh_ld = 1'b1;
                    crc_en  = 1'b1;
                end
                ST_SEQL: begin
                    seql_ld = 1'b1;
                    crc_en  = 1'b1;
                end
                ST_PAYLOAD: begin
                    store_we = 1'b1;
                    crc_en   = 1'b1;
                end
                ST_CRCH:    crch_ld   = 1'b1;
                ST_CRCL:    frame_hit = ({r_crc_high, i_item.rx_byte} == r_crc);
                default: begin
                    crc_en        = i_item.hit_first;
                    crc_from_init = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_HUNT;
            r_len      <= '0;
            r_type     <= '0;
            r_seq      <= '0;
            r_wpos     <= '0;
            r_crc      <= CRC_INIT;
            r_crc_high <= '0;
        end else begin
            r_state <= n_state;
            if (crc_en)   r_crc      <= crc_next;
            if (len_ld)   r_len      <= i_item.rx_byte;
            if (type_ld)  r_type     <= i_item.rx_byte;
            if (seqh_ld)  r_seq      <= {i_item.rx_byte, 8'h00};
            if (seql_ld)  r_seq[7:0] <= i_item.rx_byte;
            if (crch_ld)  r_crc_high <= i_item.rx_byte;
            if (wpos_clr) begin
                r_wpos <= '0;
            end else if (store_we) begin
                r_wpos <= r_wpos + 8'd1;
            end
        end
    end

    // payload store: one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_store[AW'(r_wpos)] <= i_item.rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd) begin
            r_rd_data <= r_store[AW'(i_item.read_index)];
            r_rd_oor  <= (32'(i_item.read_index) >= PAYLOAD_DEPTH);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (rd || frame_hit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd) begin
            r_out <= '{kind: KIND_READ, pkt_type: '0, pkt_seq: '0, pkt_len: '0};
        end else if (frame_hit) begin
            r_out <= '{kind: KIND_LINE, pkt_type: r_type, pkt_seq: r_seq,
                       pkt_len: r_len - MIN_LENGTH};
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_result_kind = r_out.kind;
    assign o_pkt_type    = r_out.pkt_type;
    assign o_pkt_seq     = r_out.pkt_seq;
    assign o_pkt_len     = r_out.pkt_len;
    assign o_read_data   = (r_out.kind == KIND_READ && !r_rd_oor) ? r_rd_data : 8'h00;

endmodule
`default_nettype wire

@@ hdl/srx_checker.sv @@
`default_nettype none
module srx_props (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_in_valid,
    input wire logic                            o_in_ready,
    input wire logic                            i_kind,
    input wire logic [7:0]                      i_rx_byte,
    input wire logic [7:0]                      i_read_index,
    input wire logic                            i_cfg_valid,
    input wire logic                            o_cfg_ready,
    input wire logic [srx_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input wire logic [7:0]                      i_cfg_data,
    input wire logic                            o_out_valid,
    input wire logic                            i_out_ready,
    input wire logic                            o_result_kind,
    input wire logic [7:0]                      o_pkt_type,
    input wire logic [15:0]                     o_pkt_seq,
    input wire logic [7:0]                      o_pkt_len,
    input wire logic [7:0]                      o_read_data
);
    import srx_pkg::*;

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_result_kind)
            && $stable(o_pkt_type) && $stable(o_pkt_seq) && $stable(o_pkt_len)
            && $stable(o_read_data))
        else $error("result beat changed while stalled");

    a_read_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_result_kind == KIND_READ |->
            o_pkt_type == 8'h00 && o_pkt_seq == 16'h0000 && o_pkt_len == 8'h00)
        else $error("read result carries frame fields");

    a_frame_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_result_kind == KIND_LINE |->
            o_read_data == 8'h00 && o_pkt_len <= 8'd250)
        else $error("frame result malformed");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat right after reset");

endmodule

bind sync_length_crc16_frame_receiver srx_props u_srx_props (.*);
`default_nettype wire
